FILE: rtl/e2a_pkg.sv
// ----------------------------------------------------------------------------
// e2a_pkg
// Shared types, constants and helpers for the Euler angle to axis vector
// pipeline.
// ----------------------------------------------------------------------------
package e2a_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // sine series: six nested terms
  localparam int SIN_ITERS = 6;

  // stage counts of the fixed parts of the pipeline
  localparam int SIN_LAT  = 2 + 3 * SIN_ITERS + 1;
  localparam int ROT_LAT  = 4;
  localparam int SQ_STEPS = 32;
  localparam int SQRT_LAT = 2 + SQ_STEPS;

  // component width after the rotation product (Q30, with headroom)
  localparam int VW = 34;

  // axis select codes
  localparam logic [1:0] AXIS_RIGHT = 2'd0;
  localparam logic [1:0] AXIS_UP    = 2'd1;
  localparam logic [1:0] AXIS_FWD   = 2'd2;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic [1:0]         opcode;
  } req_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } rsp_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 zero;
  } vec_t;

  function automatic logic [7:0] series_k(input int i);
    logic [7:0] k;
    case (i)
      0:       k = 8'd156;
      1:       k = 8'd110;
      2:       k = 8'd72;
      3:       k = 8'd42;
      4:       k = 8'd20;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  // Q60 -> Q30, round half away from zero
  function automatic logic signed [VW-1:0] round_q30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? -VW'(r) : VW'(r);
  endfunction

endpackage

FILE: rtl/euler_to_axis_vector.sv
// ----------------------------------------------------------------------------
// euler_to_axis_vector: unit axis vector of an X*Y*Z Euler rotation.
// One request per cycle, unless a finished result is held by rsp_stall.
// Depth is set by the sine series, the square root (one bit per stage) and
// the dividers (one quotient bit per stage). A stall freezes every stage.
// Reset clears only the valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module euler_to_axis_vector #(
  parameter int ANGLE_BITS = e2a_pkg::ANGLE_BITS,
  parameter int FRAC_BITS  = e2a_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  e2a_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output e2a_pkg::rsp_t rsp
);

  localparam int LAT = 1 + e2a_pkg::SIN_LAT + e2a_pkg::ROT_LAT + e2a_pkg::SQRT_LAT
                       + FRAC_BITS + 3;
  localparam int SL  = e2a_pkg::SIN_LAT;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic           adv;
  logic [LAT-1:0] vld;

  logic [ANGLE_BITS-1:0] ax, ay, az;
  logic [ANGLE_BITS-1:0] ang   [0:5];
  logic [ANGLE_BITS-2:0] r_c   [0:5];
  logic                  neg_c [0:5];

  logic [ANGLE_BITS-2:0] r1   [0:5];
  logic                  neg1 [0:5];
  logic [1:0]            sel1;
  logic [1:0]            sel_d [0:SL-1];

  logic signed [31:0] sc [0:5];

  e2a_pkg::vec_t      vec_r, vec_q;
  logic [31:0]        len;
  logic signed [15:0] dx, dy, dz;

  assign adv       = !(vld[LAT-1] && rsp_stall);
  assign req_stall = !adv;
  assign rsp_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], req_valid};
    end
  end

  // X and Z angles are negated; cos(a) = sin(a + quarter turn)
  assign ax = -ANGLE_BITS'(req.angle_x);
  assign ay = ANGLE_BITS'(req.angle_y);
  assign az = -ANGLE_BITS'(req.angle_z);

  assign ang[0] = ax;
  assign ang[1] = ax + QTR;
  assign ang[2] = ay;
  assign ang[3] = ay + QTR;
  assign ang[4] = az;
  assign ang[5] = az + QTR;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (ang[k][ANGLE_BITS-2]) begin
        r_c[k] = (ANGLE_BITS-1)'(QTR) - (ANGLE_BITS-1)'(ang[k][ANGLE_BITS-3:0]);
      end else begin
        r_c[k] = (ANGLE_BITS-1)'(ang[k][ANGLE_BITS-3:0]);
      end
      neg_c[k] = ang[k][ANGLE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        r1[k]   <= r_c[k];
        neg1[k] <= neg_c[k];
      end
      sel1 <= req.opcode;
    end
  end

  for (genvar gk = 0; gk < 6; gk++) begin : g_sin
    e2a_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
      .clk   (clk),
      .en    (adv),
      .r     (r1[gk]),
      .neg   (neg1[gk]),
      .value (sc[gk])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_d[0] <= sel1;
      for (int k = 1; k < SL; k++) begin
        sel_d[k] <= sel_d[k-1];
      end
    end
  end

  e2a_rot u_rot (
    .clk (clk),
    .en  (adv),
    .sx  (sc[0]),
    .cx  (sc[1]),
    .sy  (sc[2]),
    .cy  (sc[3]),
    .sz  (sc[4]),
    .cz  (sc[5]),
    .sel (sel_d[SL-1]),
    .v   (vec_r)
  );

  e2a_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .v_in  (vec_r),
    .len   (len),
    .v_out (vec_q)
  );

  e2a_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .en (adv), .v (vec_q.x), .zero (vec_q.zero), .len (len), .dir (dx)
  );

  e2a_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .en (adv), .v (vec_q.y), .zero (vec_q.zero), .len (len), .dir (dy)
  );

  e2a_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk (clk), .en (adv), .v (vec_q.z), .zero (vec_q.zero), .len (len), .dir (dz)
  );

  assign rsp = '{dir_x: dx, dir_y: dy, dir_z: dz};

endmodule

FILE: rtl/e2a_sin.sv
// ----------------------------------------------------------------------------
// e2a_sin
// Pipelined sine of a quarter-turn offset: theta, theta^2, six nested series
// terms (multiply, reciprocal divide, correct), final scale and sign.
// ----------------------------------------------------------------------------
module e2a_sin #(
  parameter int ANGLE_BITS = e2a_pkg::ANGLE_BITS
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-2:0]   r,
  input  logic                    neg,
  output logic signed [31:0]      value
);

  localparam int PW = ANGLE_BITS + 32;
  localparam int N  = e2a_pkg::SIN_ITERS;
  localparam logic [30:0] ONE = 31'(1) << 30;

  logic [PW-1:0] th_prod;
  logic [30:0]   theta1;
  logic          neg1;
  logic [61:0]   sq;

  logic [31:0] s_i   [0:N];
  logic [30:0] th_i  [0:N];
  logic        neg_i [0:N];
  logic [30:0] h_i   [1:N];

  logic [61:0] p_f;

  assign th_prod = PW'(r) * PW'(e2a_pkg::PI_Q30) + (PW'(1) << (ANGLE_BITS - 2));

  always_ff @(posedge clk) begin
    if (en) begin
      theta1 <= th_prod[ANGLE_BITS+29:ANGLE_BITS-1];
      neg1   <= neg;
    end
  end

  assign sq = 62'(theta1) * 62'(theta1) + (62'(1) << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      s_i[0]   <= sq[61:30];
      th_i[0]  <= theta1;
      neg_i[0] <= neg1;
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_it
    localparam logic [7:0]  K = e2a_pkg::series_k(gi);
    localparam logic [29:0] M = 30'((64'd1 << 32) / 64'(K));

    logic [30:0] h_in;
    logic [62:0] p_a;
    logic [61:0] p_b;
    logic [31:0] rem;
    logic [29:0] q_fix;
    logic [31:0] t_a, s_a, t_b, s_b;
    logic [30:0] th_a, th_b;
    logic        neg_a, neg_b;
    logic [29:0] q_b;

    if (gi == 0) begin : g_first
      assign h_in = ONE;
    end else begin : g_rest
      assign h_in = h_i[gi];
    end

    assign p_a = 63'(s_i[gi]) * 63'(h_in) + (63'(1) << 29);
    assign p_b = 62'(t_a) * 62'(M);
    // reciprocal estimate is at most one low
    assign rem   = t_b - 32'(q_b) * 32'(K);
    assign q_fix = q_b + 30'(rem >= 32'(K));

    always_ff @(posedge clk) begin
      if (en) begin
        t_a   <= p_a[61:30];
        s_a   <= s_i[gi];
        th_a  <= th_i[gi];
        neg_a <= neg_i[gi];

        t_b   <= t_a;
        q_b   <= p_b[61:32];
        s_b   <= s_a;
        th_b  <= th_a;
        neg_b <= neg_a;

        h_i[gi+1]   <= ONE - 31'(q_fix);
        s_i[gi+1]   <= s_b;
        th_i[gi+1]  <= th_b;
        neg_i[gi+1] <= neg_b;
      end
    end
  end

  assign p_f = 62'(th_i[N]) * 62'(h_i[N]) + (62'(1) << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      value <= neg_i[N] ? -32'(p_f[60:30]) : 32'(p_f[60:30]);
    end
  end

endmodule

FILE: rtl/e2a_rot.sv
// ----------------------------------------------------------------------------
// e2a_rot
// Selected row of the X*Y*Z rotation product, reversed, as Q30 components.
// Four stages: row products, row rounding, Z products, Z sums.
// ----------------------------------------------------------------------------
module e2a_rot (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] sx,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] sy,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] sz,
  input  logic signed [31:0] cz,
  input  logic [1:0]         sel,
  output e2a_pkg::vec_t      v
);

  localparam int VW = e2a_pkg::VW;

  logic signed [31:0] m;
  logic signed [32:0] a1_c;
  logic signed [63:0] p0_c, p2_c;

  logic signed [63:0] p0, p2;
  logic signed [32:0] a1_1;
  logic signed [31:0] cy1, sy1, sz1, cz1;
  logic [1:0]         sel1;

  logic signed [32:0] a0, a1_2, a2;
  logic signed [31:0] sz2, cz2;
  logic               zero2;

  logic signed [63:0] m_a0sz, m_a1cz, m_a0cz, m_a1sz;
  logic signed [63:0] m_a0sz_c, m_a1cz_c, m_a0cz_c, m_a1sz_c;
  logic signed [32:0] a2_3;
  logic               zero3;

  // X*Y row: right = [cy, 0, -sy], up/forward share the products with sx or cx
  assign m = (sel == e2a_pkg::AXIS_UP) ? sx : cx;

  always_comb begin
    unique case (sel)
      e2a_pkg::AXIS_RIGHT: a1_c = '0;
      e2a_pkg::AXIS_UP:    a1_c = 33'(cx);
      e2a_pkg::AXIS_FWD:   a1_c = -33'(sx);
      default:             a1_c = '0;
    endcase
  end

  assign p0_c = m * sy;
  assign p2_c = m * cy;

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= p0_c;
      p2   <= p2_c;
      a1_1 <= a1_c;
      cy1  <= cy;
      sy1  <= sy;
      sz1  <= sz;
      cz1  <= cz;
      sel1 <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= (sel1 == e2a_pkg::AXIS_RIGHT) ? 33'(cy1) : 33'(e2a_pkg::round_q30(p0));
      a2    <= (sel1 == e2a_pkg::AXIS_RIGHT) ? -33'(sy1) : 33'(e2a_pkg::round_q30(p2));
      a1_2  <= a1_1;
      sz2   <= sz1;
      cz2   <= cz1;
      zero2 <= (sel1 > e2a_pkg::AXIS_FWD);
    end
  end

  assign m_a0sz_c = a0 * sz2;
  assign m_a1cz_c = a1_2 * cz2;
  assign m_a0cz_c = a0 * cz2;
  assign m_a1sz_c = a1_2 * sz2;

  always_ff @(posedge clk) begin
    if (en) begin
      m_a0sz <= m_a0sz_c;
      m_a1cz <= m_a1cz_c;
      m_a0cz <= m_a0cz_c;
      m_a1sz <= m_a1sz_c;
      a2_3   <= a2;
      zero3  <= zero2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v.x    <= VW'(a2_3);
      v.y    <= e2a_pkg::round_q30(m_a0sz + m_a1cz);
      v.z    <= e2a_pkg::round_q30(m_a0cz - m_a1sz);
      v.zero <= zero3;
    end
  end

endmodule

FILE: rtl/e2a_sqrt.sv
// ----------------------------------------------------------------------------
// e2a_sqrt
// Squared length of the vector, then a floor square root, one result bit
// per stage. The vector travels alongside.
// ----------------------------------------------------------------------------
module e2a_sqrt (
  input  logic          clk,
  input  logic          en,
  input  e2a_pkg::vec_t v_in,
  output logic [31:0]   len,
  output e2a_pkg::vec_t v_out
);

  localparam int NS = e2a_pkg::SQ_STEPS;
  localparam int VW = e2a_pkg::VW;

  logic signed [2*VW-1:0] px, py, pz;
  logic [63:0]            sq_x, sq_y, sq_z;
  e2a_pkg::vec_t          side1;

  logic [34:0]   rem_p  [0:NS];
  logic [31:0]   root_p [0:NS];
  logic [63:0]   n_p    [0:NS];
  e2a_pkg::vec_t side_p [0:NS];

  assign px = v_in.x * v_in.x;
  assign py = v_in.y * v_in.y;
  assign pz = v_in.z * v_in.z;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= px[63:0];
      sq_y  <= py[63:0];
      sq_z  <= pz[63:0];
      side1 <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p[0]    <= sq_x + sq_y + sq_z;
      rem_p[0]  <= '0;
      root_p[0] <= '0;
      side_p[0] <= side1;
    end
  end

  for (genvar gi = 0; gi < NS; gi++) begin : g_step
    logic [34:0] cur;
    logic [34:0] trial;
    logic        ge;

    // bring down the next two bits; trial is 4*root + 1
    assign cur   = {rem_p[gi][32:0], n_p[gi][63:62]};
    assign trial = {1'b0, root_p[gi], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[gi+1]  <= ge ? (cur - trial) : cur;
        root_p[gi+1] <= {root_p[gi][30:0], ge};
        n_p[gi+1]    <= n_p[gi] << 2;
        side_p[gi+1] <= side_p[gi];
      end
    end
  end

  assign len   = root_p[NS];
  assign v_out = side_p[NS];

endmodule

FILE: rtl/e2a_div.sv
// ----------------------------------------------------------------------------
// e2a_div
// Scales one component by the vector length: rounded restoring division,
// one quotient bit per stage, then saturation and sign; zero for a zero vector or length.
// ----------------------------------------------------------------------------
module e2a_div #(
  parameter int FRAC_BITS = e2a_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [e2a_pkg::VW-1:0] v,
  input  logic                         zero,
  input  logic [31:0]                  len,
  output logic signed [15:0]           dir
);

  localparam int VW = e2a_pkg::VW;
  localparam int DW = VW + 1 + FRAC_BITS;
  localparam int NS = FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] LIM = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [VW-1:0] mag;

  logic [DW-1:0]      r_p    [0:NS];
  logic [31:0]        len_p  [0:NS];
  logic [FRAC_BITS:0] q_p    [0:NS];
  logic               neg_p  [0:NS];
  logic               zero_p [0:NS];

  logic [FRAC_BITS:0] q_sat;
  logic [31:0]        q_ext;

  assign mag = v[VW-1] ? VW'(-v) : VW'(v);

  always_ff @(posedge clk) begin
    if (en) begin
      r_p[0]    <= (DW'(mag) << FRAC_BITS) + DW'(len >> 1);
      len_p[0]  <= len;
      q_p[0]    <= '0;
      neg_p[0]  <= v[VW-1];
      zero_p[0] <= zero || (len == '0);
    end
  end

  // component magnitude never exceeds the length, so the quotient fits
  for (genvar gi = 0; gi < NS; gi++) begin : g_step
    logic [DW-1:0] dv;
    logic          ge;

    assign dv = DW'(len_p[gi]) << (FRAC_BITS - gi);
    assign ge = (r_p[gi] >= dv);

    always_ff @(posedge clk) begin
      if (en) begin
        r_p[gi+1]    <= ge ? (r_p[gi] - dv) : r_p[gi];
        q_p[gi+1]    <= {q_p[gi][FRAC_BITS-1:0], ge};
        len_p[gi+1]  <= len_p[gi];
        neg_p[gi+1]  <= neg_p[gi];
        zero_p[gi+1] <= zero_p[gi];
      end
    end
  end

  assign q_sat = (q_p[NS] > LIM) ? LIM : q_p[NS];
  assign q_ext = 32'(q_sat);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_p[NS]) begin
        dir <= '0;
      end else if (neg_p[NS]) begin
        dir <= 16'(-q_ext);
      end else begin
        dir <= 16'(q_ext);
      end
    end
  end

endmodule

FILE: rtl/e2a_chk.sv
// ----------------------------------------------------------------------------
// e2a_chk
// Port-level checks for euler_to_axis_vector, bound to the top level.
// ----------------------------------------------------------------------------
module e2a_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input e2a_pkg::rsp_t rsp
);

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // the request side is held exactly while a finished result is refused
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    req_stall == (rsp_valid && rsp_stall))
    else $error("request stall does not follow output backpressure");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

endmodule

bind euler_to_axis_vector e2a_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
